/* rtl/core/wcm_pkg.sv */
// Shared types and constants for the wall column texture mapper.
// Used by every module under rtl/core; depends on nothing else.

package wcm_pkg;

    // Fixed point format and texture limits
    localparam int FRAC_BITS    = 16;
    localparam int MAX_TEX_LOG2 = 8;

    // Field widths
    localparam int Q_W      = 24;
    localparam int HEIGHT_W = 11;
    localparam int TEXW_W   = 9;
    localparam int LOG2_W   = 4;
    localparam int COL_W    = 11;
    localparam int TID_W    = 3;
    localparam int ROW_W    = 10;
    localparam int TEXC_W   = 8;
    localparam int POS_W    = 32;
    localparam int LINE_W   = 16;
    localparam int OFF_W    = LINE_W - 1;

    // Shared divider: numerator holds screen height above the fraction
    localparam int DIV_NUM_W = HEIGHT_W + FRAC_BITS;
    localparam int DIV_DEN_W = Q_W;

    // Signed ray component is split for two narrow partial products
    localparam int MUL_SPLIT = 12;

    // Saturation limits
    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [Q_W-1:0]    STEP_MAX = {Q_W{1'b1}};
    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = HEIGHT_W'(1024);
    localparam logic [TEXW_W-1:0]   TEXW_LIMIT   = TEXW_W'(256);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT_LOG2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y        = 3'd4;

    // Item modes and result kinds
    localparam logic MODE_SETUP = 1'b0;
    localparam logic MODE_ROW   = 1'b1;
    localparam logic KIND_SETUP = 1'b0;
    localparam logic KIND_ROW   = 1'b1;

    // Effective configuration, already clamped to legal ranges
    typedef struct packed {
        logic [HEIGHT_W-1:0] eff_height;
        logic [TEXW_W-1:0]   tex_w;
        logic [LOG2_W-1:0]   tex_log2;
        logic [Q_W-1:0]      player_x;
        logic [Q_W-1:0]      player_y;
    } cfg_t;

    // Classified item as it sits in the queue
    typedef struct packed {
        logic             mode;
        logic [COL_W-1:0] column;
        logic [TID_W-1:0] texture;
        logic [Q_W-1:0]   perp_dist;
        logic             side;
        logic [Q_W-1:0]   ray;     // ray component along the wall, signed
        logic             mirror;  // texture column runs backwards
    } item_t;

    // One result item
    typedef struct packed {
        logic              kind;
        logic              valid_res;
        logic [COL_W-1:0]  column;
        logic [TID_W-1:0]  texture;
        logic [ROW_W-1:0]  screen_row;
        logic [TEXC_W-1:0] tex_col;
        logic [TEXC_W-1:0] tex_row;
        logic [ROW_W-1:0]  draw_start;
        logic [ROW_W-1:0]  draw_end;
        logic              last;
    } res_t;

endpackage

/* rtl/core/wcm_front.sv */
// Front end: takes input transfers, picks the ray component and mirror flag.
// Depends on wcm_pkg; feeds wcm_queue.

module wcm_front
    import wcm_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // column, texture_id, perp_dist, hit_side,
                                       // ray_dir_x, ray_dir_y, zero pad
    input  logic [0:0]  s_axis_tuser,  // mode
    input  logic        q_full,
    output logic        push,
    output item_t       push_item
);

    logic [Q_W-1:0] rdx;
    logic [Q_W-1:0] rdy;
    logic           side;

    assign rdx  = s_axis_tdata[62:39];
    assign rdy  = s_axis_tdata[86:63];
    assign side = s_axis_tdata[38];

    // Accept whenever the queue has room
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    // Classify: wall coordinate comes from y for a vertical hit, x otherwise;
    // mirror for a positive x ray on a vertical hit or a negative y ray on a
    // horizontal hit
    always_comb
    begin
        push_item.mode      = s_axis_tuser[0];
        push_item.column    = s_axis_tdata[10:0];
        push_item.texture   = s_axis_tdata[13:11];
        push_item.perp_dist = s_axis_tdata[37:14];
        push_item.side      = side;
        push_item.ray       = side ? rdx : rdy;
        push_item.mirror    = side ? rdy[Q_W-1]
                                   : (!rdx[Q_W-1] && (rdx != '0));
    end

endmodule

/* rtl/core/wcm_queue.sv */
// Short FIFO of classified items between front and back end.
// Depends on wcm_pkg (item_t).

module wcm_queue
    import wcm_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  nonempty,
    output item_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = slot_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // No write into a full queue, no read from an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH)) || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

endmodule

/* rtl/core/wcm_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wcm_pkg for operand widths; shared by the back end.

module wcm_div
    import wcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic [DIV_NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg;
    logic                 busy_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] num_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] den_next;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_NUM_W-1:0] quot_reg;
    logic [DIV_NUM_W-1:0] quot_next;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign busy = busy_reg;
    assign quot = quot_reg;

    // One trial subtraction per cycle
    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_next  = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quot_next = {quot_reg[DIV_NUM_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

endmodule

/* rtl/core/wcm_back.sv */
// Back end: column set-up sequencer, per-row stepping and output register.
// Depends on wcm_pkg and wcm_div.

module wcm_back
    import wcm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_nonempty,
    input  item_t q_head,
    output logic  q_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL_HI   = 3'd1;
    localparam logic [2:0] ST_TEXCOL   = 3'd2;
    localparam logic [2:0] ST_DIV_H    = 3'd3;
    localparam logic [2:0] ST_STEP_GO  = 3'd4;
    localparam logic [2:0] ST_DIV_STEP = 3'd5;
    localparam logic [2:0] ST_POS      = 3'd6;
    localparam logic [2:0] ST_EMIT     = 3'd7;

    localparam int PLO_W = Q_W + MUL_SPLIT;
    localparam int PHI_W = Q_W + 1 + (Q_W - MUL_SPLIT);
    localparam int TXP_W = FRAC_BITS + TEXW_W;
    localparam int TPF_W = OFF_W + Q_W;

    // Sequencer and set-up working registers
    logic [2:0]          state_reg, state_next;
    logic [Q_W-1:0]      pd_reg, pd_next;
    logic [Q_W-1:0]      ray_reg, ray_next;
    logic                side_reg, side_next;
    logic                mirror_reg, mirror_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [TID_W-1:0]    tid_reg, tid_next;
    logic [POS_W-1:0]    plo_reg, plo_next;
    logic [POS_W-1:0]    prod_reg, prod_next;
    logic [TEXC_W-1:0]   txc_reg, txc_next;
    logic [LINE_W-1:0]   line_h_reg, line_h_next;
    logic [ROW_W-1:0]    start_reg, start_next;
    logic [ROW_W-1:0]    end_reg, end_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [Q_W-1:0]      step_reg, step_next;
    logic [POS_W-1:0]    tpos_reg, tpos_next;

    // Column state
    logic [ROW_W-1:0]    row_now_reg, row_now_next;
    logic [ROW_W-1:0]    row_stop_reg, row_stop_next;
    logic [POS_W-1:0]    tex_pos_reg, tex_pos_next;
    logic [Q_W-1:0]      tex_step_reg, tex_step_next;
    logic [TEXC_W-1:0]   slice_tex_col_reg, slice_tex_col_next;
    logic [COL_W-1:0]    slice_column_reg, slice_column_next;
    logic [TID_W-1:0]    slice_texture_reg, slice_texture_next;
    logic                slice_active_reg, slice_active_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    res_t                out_res_reg, out_res_next;

    // Divider hookup
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] div_quot;

    // Datapath intermediates
    logic                     out_free;
    logic [PLO_W-1:0]         plo_full;
    logic signed [PHI_W-1:0]  phi_full;
    logic [Q_W-1:0]           pos_sel;
    logic [FRAC_BITS-1:0]     frac;
    logic [TXP_W-1:0]         txp;
    logic [TEXW_W-1:0]        tx;
    logic [TEXW_W-1:0]        tx_mir;
    logic [ROW_W-1:0]         hh;
    logic [OFF_W-1:0]         lh2;
    logic [LINE_W-1:0]        end_sum;
    logic [DIV_NUM_W-1:0]     step_num;
    logic [TPF_W-1:0]         tpos_full;
    logic [MAX_TEX_LOG2:0]    hmask;
    logic [TEXC_W-1:0]        tex_row;
    logic [ROW_W-1:0]         row_inc;
    logic                     row_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    wcm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Wall hit product pd * ray, low bits only, split in two partial products
    assign plo_full = PLO_W'(q_head.perp_dist) * PLO_W'(q_head.ray[MUL_SPLIT-1:0]);
    assign phi_full = PHI_W'($signed({1'b0, pd_reg})) *
                      PHI_W'($signed(ray_reg[Q_W-1:MUL_SPLIT]));

    // Texture column from the fractional hit position
    assign pos_sel = side_reg ? cfg.player_x : cfg.player_y;
    assign frac    = pos_sel[FRAC_BITS-1:0] + prod_reg[2*FRAC_BITS-1:FRAC_BITS];
    assign txp     = TXP_W'(frac) * TXP_W'(cfg.tex_w);
    assign tx      = txp[TXP_W-1:FRAC_BITS];
    assign tx_mir  = cfg.tex_w - tx - 1'b1;

    // Slice rows from the line height
    assign hh      = cfg.eff_height[HEIGHT_W-1:1];
    assign lh2     = line_h_reg[LINE_W-1:1];
    assign end_sum = LINE_W'(hh) + LINE_W'(lh2);

    // Texture step numerator is the texture height in fixed point
    assign step_num  = DIV_NUM_W'(1) << (int'(cfg.tex_log2) + FRAC_BITS);
    assign tpos_full = TPF_W'(off_reg) * TPF_W'(step_reg);

    // Per-row texture row with wrap to the texture height
    assign hmask    = ((MAX_TEX_LOG2 + 1)'(1) << cfg.tex_log2) - 1'b1;
    assign tex_row  = tex_pos_reg[FRAC_BITS+TEXC_W-1:FRAC_BITS] & hmask[TEXC_W-1:0];
    assign row_inc  = row_now_reg + 1'b1;
    assign row_last = (row_inc >= row_stop_reg);

    // Divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = {cfg.eff_height, {FRAC_BITS{1'b0}}};
        div_den   = q_head.perp_dist;
        if (state_reg == ST_IDLE)
        begin
            div_start = q_nonempty && (q_head.mode == MODE_SETUP)
                        && (q_head.perp_dist != '0);
        end
        else if (state_reg == ST_STEP_GO)
        begin
            div_start = 1'b1;
            div_num   = step_num;
            div_den   = DIV_DEN_W'(line_h_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        pd_next            = pd_reg;
        ray_next           = ray_reg;
        side_next          = side_reg;
        mirror_next        = mirror_reg;
        col_next           = col_reg;
        tid_next           = tid_reg;
        plo_next           = plo_reg;
        prod_next          = prod_reg;
        txc_next           = txc_reg;
        line_h_next        = line_h_reg;
        start_next         = start_reg;
        end_next           = end_reg;
        off_next           = off_reg;
        step_next          = step_reg;
        tpos_next          = tpos_reg;
        row_now_next       = row_now_reg;
        row_stop_next      = row_stop_reg;
        tex_pos_next       = tex_pos_reg;
        tex_step_next      = tex_step_reg;
        slice_tex_col_next = slice_tex_col_reg;
        slice_column_next  = slice_column_reg;
        slice_texture_next = slice_texture_reg;
        slice_active_next  = slice_active_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_res_next       = out_res_reg;
        q_pop              = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_nonempty && (q_head.mode == MODE_SETUP))
                begin
                    // Latch the set-up item, first partial product
                    q_pop       = 1'b1;
                    pd_next     = q_head.perp_dist;
                    ray_next    = q_head.ray;
                    side_next   = q_head.side;
                    mirror_next = q_head.mirror;
                    col_next    = q_head.column;
                    tid_next    = q_head.texture;
                    plo_next    = plo_full[POS_W-1:0];
                    state_next  = ST_MUL_HI;
                end
                else if (q_nonempty && out_free)
                begin
                    // Row step, one per cycle while the output register is free
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    out_res_next   = '0;
                    out_res_next.kind = KIND_ROW;
                    if (slice_active_reg)
                    begin
                        out_res_next.valid_res  = 1'b1;
                        out_res_next.column     = slice_column_reg;
                        out_res_next.texture    = slice_texture_reg;
                        out_res_next.screen_row = row_now_reg;
                        out_res_next.tex_col    = slice_tex_col_reg;
                        out_res_next.tex_row    = tex_row;
                        out_res_next.last       = row_last;
                        tex_pos_next = tex_pos_reg + POS_W'(tex_step_reg);
                        row_now_next = row_inc;
                        if (row_last)
                        begin
                            slice_active_next = 1'b0;
                        end
                    end
                end
            end

            ST_MUL_HI:
            begin
                prod_next  = plo_reg + {phi_full[POS_W-MUL_SPLIT-1:0], {MUL_SPLIT{1'b0}}};
                state_next = ST_TEXCOL;
            end

            ST_TEXCOL:
            begin
                txc_next   = mirror_reg ? tx_mir[TEXC_W-1:0] : tx[TEXC_W-1:0];
                state_next = ST_DIV_H;
            end

            ST_DIV_H:
            begin
                // Zero distance gives the tallest slice
                if (pd_reg == '0)
                begin
                    line_h_next = LINE_MAX;
                    state_next  = ST_STEP_GO;
                end
                else if (!div_busy)
                begin
                    if (div_quot > DIV_NUM_W'(LINE_MAX))
                    begin
                        line_h_next = LINE_MAX;
                    end
                    else if (div_quot == '0)
                    begin
                        line_h_next = LINE_W'(1);
                    end
                    else
                    begin
                        line_h_next = div_quot[LINE_W-1:0];
                    end
                    state_next = ST_STEP_GO;
                end
            end

            ST_STEP_GO:
            begin
                // Clamp the slice to the screen while the step divides
                if (OFF_W'(hh) > lh2)
                begin
                    start_next = hh - lh2[ROW_W-1:0];
                    off_next   = '0;
                end
                else
                begin
                    start_next = '0;
                    off_next   = lh2 - OFF_W'(hh);
                end
                if (end_sum >= LINE_W'(cfg.eff_height))
                begin
                    end_next = ROW_W'(cfg.eff_height - 1'b1);
                end
                else
                begin
                    end_next = end_sum[ROW_W-1:0];
                end
                state_next = ST_DIV_STEP;
            end

            ST_DIV_STEP:
            begin
                if (!div_busy)
                begin
                    step_next  = (div_quot > DIV_NUM_W'(STEP_MAX)) ? STEP_MAX
                                                                  : div_quot[Q_W-1:0];
                    state_next = ST_POS;
                end
            end

            ST_POS:
            begin
                tpos_next  = tpos_full[POS_W-1:0];
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_res_next            = '0;
                    out_res_next.kind       = KIND_SETUP;
                    out_res_next.valid_res  = (start_reg < end_reg);
                    out_res_next.column     = col_reg;
                    out_res_next.texture    = tid_reg;
                    out_res_next.tex_col    = txc_reg;
                    out_res_next.draw_start = start_reg;
                    out_res_next.draw_end   = end_reg;
                    // New column replaces any column still in progress
                    row_now_next       = start_reg;
                    row_stop_next      = end_reg;
                    tex_pos_next       = tpos_reg;
                    tex_step_next      = step_reg;
                    slice_tex_col_next = txc_reg;
                    slice_column_next  = col_reg;
                    slice_texture_next = tid_reg;
                    slice_active_next  = (start_reg < end_reg);
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and column state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            row_now_reg       <= '0;
            row_stop_reg      <= '0;
            tex_pos_reg       <= '0;
            tex_step_reg      <= '0;
            slice_tex_col_reg <= '0;
            slice_column_reg  <= '0;
            slice_texture_reg <= '0;
            slice_active_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            row_now_reg       <= row_now_next;
            row_stop_reg      <= row_stop_next;
            tex_pos_reg       <= tex_pos_next;
            tex_step_reg      <= tex_step_next;
            slice_tex_col_reg <= slice_tex_col_next;
            slice_column_reg  <= slice_column_next;
            slice_texture_reg <= slice_texture_next;
            slice_active_reg  <= slice_active_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pd_reg      <= pd_next;
        ray_reg     <= ray_next;
        side_reg    <= side_next;
        mirror_reg  <= mirror_next;
        col_reg     <= col_next;
        tid_reg     <= tid_next;
        plo_reg     <= plo_next;
        prod_reg    <= prod_next;
        txc_reg     <= txc_next;
        line_h_reg  <= line_h_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        off_reg     <= off_next;
        step_reg    <= step_next;
        tpos_reg    <= tpos_next;
        out_res_reg <= out_res_next;
    end

    // An active column always has rows left
    a_active_rows: assert property (@(posedge clk) disable iff (!rst_n)
        slice_active_reg |-> (row_now_reg < row_stop_reg))
        else $error("active column with no rows left");

    // The shared divider is never restarted mid-division
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // The step division never sees a zero line height
    a_step_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP_GO) |-> (line_h_reg != '0))
        else $error("zero line height at step division");

    // Queue is only drained when an item is present
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_nonempty)
        else $error("pop without queued item");

endmodule

/* rtl/core/wall_column_texture_mapper_unit.sv */
// Top level of the wall column texture mapper: configuration registers,
// front end, item queue and back end. Depends on wcm_pkg and all wcm_ modules.
// Usage:
//   Input stream s_axis_*: tuser selects set-up (0) or row (1). A set-up
//   transfer carries one screen column's distance, hit side and ray; each
//   row transfer then yields one pixel of that column's wall slice.
//   Output stream m_axis_*: one result transfer per input transfer, in order.
//   tuser[0] is the kind, tuser[1] says a row holds a pixel or a set-up has
//   rows pending, tlast marks the final row of the column.
//   Configuration: cfg_valid/cfg_index/cfg_data write one register; always
//   ready. Write only while the block is idle.
// Timing: rows stream one per cycle while no set-up is in progress and the output
//   is not stalled, each passing through the item queue and the output register.
//   A set-up item runs a 27-step bit-serial division for the slice height (skipped
//   at zero distance), another for the texture step, and the set-up multiplies.
// Reset: registers return to 480 rows, 64 texels wide, height log2 6, player
//   at the origin; no column is active and the queue is empty.
// Stall: the output register holds its result while m_axis_tready is low; the
//   queue keeps taking input until it is full, then s_axis_tready drops.

module wall_column_texture_mapper_unit
    import wcm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [87:0]          s_axis_tdata,  // column, texture_id, perp_dist,
                                                // hit_side, ray_dir_x, ray_dir_y, pad
    input  logic [0:0]           s_axis_tuser,  // mode

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // out_column, out_texture, screen_row,
                                                // tex_col, tex_row, draw_start,
                                                // draw_end, pad
    output logic [1:0]           m_axis_tuser,  // kind, valid_res
    output logic                 m_axis_tlast,  // last

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data
);

    logic [HEIGHT_W-1:0] screen_height_reg;
    logic [TEXW_W-1:0]   tex_width_reg;
    logic [LOG2_W-1:0]   tex_height_log2_reg;
    logic [Q_W-1:0]      player_x_reg;
    logic [Q_W-1:0]      player_y_reg;
    cfg_t                cfg;

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  q_pop;
    logic  q_nonempty;
    item_t q_head;
    res_t  res;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg   <= HEIGHT_W'(480);
            tex_width_reg       <= TEXW_W'(64);
            tex_height_log2_reg <= LOG2_W'(6);
            player_x_reg        <= '0;
            player_y_reg        <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_data[HEIGHT_W-1:0];
                REG_TEX_WIDTH:       tex_width_reg       <= cfg_data[TEXW_W-1:0];
                REG_TEX_HEIGHT_LOG2: tex_height_log2_reg <= cfg_data[LOG2_W-1:0];
                REG_PLAYER_X:        player_x_reg        <= cfg_data;
                REG_PLAYER_Y:        player_y_reg        <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Clamp registers to their usable ranges
    always_comb
    begin
        cfg.eff_height = (screen_height_reg == '0) ? HEIGHT_W'(1)
                       : (screen_height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT
                       : screen_height_reg;
        cfg.tex_w      = (tex_width_reg == '0) ? TEXW_W'(1)
                       : (tex_width_reg > TEXW_LIMIT) ? TEXW_LIMIT
                       : tex_width_reg;
        cfg.tex_log2   = (tex_height_log2_reg > LOG2_W'(MAX_TEX_LOG2))
                       ? LOG2_W'(MAX_TEX_LOG2) : tex_height_log2_reg;
        cfg.player_x   = player_x_reg;
        cfg.player_y   = player_y_reg;
    end

    wcm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    wcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    wcm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    // Result packing
    assign m_axis_tdata = {4'b0, res.draw_end, res.draw_start, res.tex_row, res.tex_col,
                           res.screen_row, res.texture, res.column};
    assign m_axis_tuser = {res.valid_res, res.kind};
    assign m_axis_tlast = res.last;

endmodule

/* tb/testbench.sv */
// Self-checking bench for wall_column_texture_mapper_unit: column set-up and row transfers
// with random gaps and stalls, checked against a cycle-free model held in a scoreboard class.
// Depends on wcm_pkg and the RTL under rtl/core.

module testbench;
    import wcm_pkg::*;

    typedef longint unsigned u64_t;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 300;

    // Expected-result store plus a model of the column state and registers
    class column_scoreboard;
        logic [HEIGHT_W-1:0] scr_h;
        logic [TEXW_W-1:0]   tex_w;
        logic [LOG2_W-1:0]   tex_log2;
        logic [Q_W-1:0]      px;
        logic [Q_W-1:0]      py;

        logic [ROW_W-1:0]    row_now;
        logic [ROW_W-1:0]    row_stop;
        logic [POS_W-1:0]    tex_pos;
        logic [Q_W-1:0]      tex_step;
        logic [TEXC_W-1:0]   slice_tex_col;
        logic [COL_W-1:0]    slice_col;
        logic [TID_W-1:0]    slice_tid;
        bit                  active;

        res_t                expected_q[$];
        int                  errors;

        function new();
            scr_h         = HEIGHT_W'(480);
            tex_w         = TEXW_W'(64);
            tex_log2      = LOG2_W'(6);
            px            = '0;
            py            = '0;
            row_now       = '0;
            row_stop      = '0;
            tex_pos       = '0;
            tex_step      = '0;
            slice_tex_col = '0;
            slice_col     = '0;
            slice_tid     = '0;
            active        = 1'b0;
            errors        = 0;
        endfunction

        function logic [HEIGHT_W-1:0] eff_height();
            if (scr_h == '0)
                return HEIGHT_W'(1);
            if (scr_h > HEIGHT_LIMIT)
                return HEIGHT_LIMIT;
            return scr_h;
        endfunction

        function int eff_log2();
            if (int'(tex_log2) > MAX_TEX_LOG2)
                return MAX_TEX_LOG2;
            return int'(tex_log2);
        endfunction

        function int rows_left();
            if (!active)
                return 0;
            return int'(row_stop) - int'(row_now);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
            case (idx)
                REG_SCREEN_HEIGHT:   scr_h    = data[HEIGHT_W-1:0];
                REG_TEX_WIDTH:       tex_w    = data[TEXW_W-1:0];
                REG_TEX_HEIGHT_LOG2: tex_log2 = data[LOG2_W-1:0];
                REG_PLAYER_X:        px       = data;
                REG_PLAYER_Y:        py       = data;
                default: ;
            endcase
        endfunction

        // Accepted input transfer: advance the column state and queue its result
        function void note_item(input logic mode, input logic [COL_W-1:0] col,
                                input logic [TID_W-1:0] tid, input logic [Q_W-1:0] pdist,
                                input logic side, input logic [Q_W-1:0] rdx,
                                input logic [Q_W-1:0] rdy);
            u64_t    h;
            u64_t    w;
            u64_t    line_h;
            u64_t    half_h;
            u64_t    half_l;
            u64_t    first;
            u64_t    stop;
            u64_t    pos;
            u64_t    uprod;
            u64_t    frac;
            u64_t    tcol;
            u64_t    step;
            longint  rx;
            longint  ry;
            longint  dist_v;
            longint  prod;
            res_t    r;

            r  = '0;
            rx = $signed(rdx);
            ry = $signed(rdy);
            dist_v = pdist;

            if (mode == MODE_SETUP)
            begin
                // slice height, saturated
                h = eff_height();
                if (pdist == '0)
                    line_h = LINE_MAX;
                else
                    line_h = (h << FRAC_BITS) / u64_t'(pdist);
                if (line_h > LINE_MAX)
                    line_h = LINE_MAX;
                if (line_h == 0)
                    line_h = 1;

                // clamped row span
                half_h = h / 2;
                half_l = line_h / 2;
                first  = (half_h > half_l) ? half_h - half_l : 0;
                stop   = half_l + half_h;
                if (stop >= h)
                    stop = h - 1;

                // fractional hit point along the wall
                pos   = side ? u64_t'(px) : u64_t'(py);
                prod  = dist_v * (side ? rx : ry);
                uprod = prod;
                frac  = (pos + (uprod >> FRAC_BITS)) & ((u64_t'(1) << FRAC_BITS) - 1);

                w = tex_w;
                if (w == 0)
                    w = 1;
                if (w > TEXW_LIMIT)
                    w = TEXW_LIMIT;
                tcol = (frac * w) >> FRAC_BITS;
                if ((!side && rx > 0) || (side && ry < 0))
                    tcol = w - tcol - 1;

                step = (u64_t'(1) << (eff_log2() + FRAC_BITS)) / line_h;
                if (step > STEP_MAX)
                    step = STEP_MAX;

                tex_step      = Q_W'(step);
                tex_pos       = POS_W'((first + half_l - half_h) * step);
                row_now       = ROW_W'(first);
                row_stop      = ROW_W'(stop);
                slice_tex_col = TEXC_W'(tcol);
                slice_col     = col;
                slice_tid     = tid;
                active        = (first < stop);

                r.kind       = KIND_SETUP;
                r.valid_res  = active;
                r.column     = slice_col;
                r.texture    = slice_tid;
                r.tex_col    = slice_tex_col;
                r.draw_start = ROW_W'(first);
                r.draw_end   = ROW_W'(stop);
            end
            else
            begin
                r.kind = KIND_ROW;
                if (active)
                begin
                    r.valid_res  = 1'b1;
                    r.column     = slice_col;
                    r.texture    = slice_tid;
                    r.screen_row = row_now;
                    r.tex_col    = slice_tex_col;
                    // wrap uses the texture height in force right now
                    r.tex_row    = TEXC_W'((u64_t'(tex_pos) >> FRAC_BITS)
                                           & ((u64_t'(1) << eff_log2()) - 1));
                    tex_pos = tex_pos + {{(POS_W-Q_W){1'b0}}, tex_step};
                    row_now = row_now + 1'b1;
                    if (row_now >= row_stop)
                    begin
                        r.last = 1'b1;
                        active = 1'b0;
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h, expected %0h", name, got, want));
        endtask

        // Accepted output transfer against the oldest expectation
        task check_result(input res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                report("result transfer with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind",       32'(got.kind),       32'(want.kind));
            compare_field("valid_res",  32'(got.valid_res),  32'(want.valid_res));
            compare_field("out_column", 32'(got.column),     32'(want.column));
            compare_field("out_texture",32'(got.texture),    32'(want.texture));
            compare_field("screen_row", 32'(got.screen_row), 32'(want.screen_row));
            compare_field("tex_col",    32'(got.tex_col),    32'(want.tex_col));
            compare_field("tex_row",    32'(got.tex_row),    32'(want.tex_row));
            compare_field("draw_start", 32'(got.draw_start), 32'(want.draw_start));
            compare_field("draw_end",   32'(got.draw_end),   32'(want.draw_end));
            compare_field("last",       32'(got.last),       32'(want.last));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [87:0]          s_axis_tdata = '0;   // column, texture_id, perp_dist, hit_side,
                                               // ray_dir_x, ray_dir_y, pad
    logic [0:0]           s_axis_tuser = '0;   // mode

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;        // out_column, out_texture, screen_row, tex_col,
                                               // tex_row, draw_start, draw_end, pad
    logic [1:0]           m_axis_tuser;        // kind, valid_res
    logic                 m_axis_tlast;        // last

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [Q_W-1:0]       cfg_data = '0;

    column_scoreboard     sb;
    int                   items_sent = 0;
    int                   cycle_count = 0;
    bit                   offering = 1'b0;
    bit                   no_idle = 1'b0;
    logic                 hold_out = 1'b0;
    bit                   rx_on = 1'b1;
    int                   rx_run = 0;

    wall_column_texture_mapper_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function logic [Q_W-1:0] rand_ray();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return {1'b1, {(Q_W-1){1'b0}}};
            2:       return {1'b0, {(Q_W-1){1'b1}}};
            default: return Q_W'($urandom);
        endcase
    endfunction

    // One input transfer, preceded by a random gap
    task send_item(input logic mode, input logic [COL_W-1:0] col, input logic [TID_W-1:0] tid,
                   input logic [Q_W-1:0] pdist, input logic side,
                   input logic [Q_W-1:0] rdx, input logic [Q_W-1:0] rdy);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            if (offering)
                s_axis_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (!offering)
            s_axis_tvalid <= 1'b1;
        offering = 1'b1;
        s_axis_tdata <= {1'b0, rdy, rdx, side, pdist, tid, col};
        s_axis_tuser <= mode;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(mode, col, tid, pdist, side, rdx, rdy);
        items_sent++;
    endtask

    // Row transfers; the fields they carry besides mode are ignored
    task send_rows(input int n);
        repeat (n)
            send_item(MODE_ROW, COL_W'($urandom), TID_W'($urandom), Q_W'($urandom),
                      1'($urandom), Q_W'($urandom), Q_W'($urandom));
    endtask

    // Stop offering and wait for every outstanding result
    task drain();
        if (offering)
            s_axis_tvalid <= 1'b0;
        offering = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Writes all five registers back to back
    task program_regs(input logic [Q_W-1:0] h, input logic [Q_W-1:0] w,
                      input logic [Q_W-1:0] l, input logic [Q_W-1:0] x,
                      input logic [Q_W-1:0] y);
        logic [Q_W-1:0]       vals[5];
        logic [CFG_IDX_W-1:0] idx[5];
        vals = '{h, w, l, x, y};
        idx  = '{REG_SCREEN_HEIGHT, REG_TEX_WIDTH, REG_TEX_HEIGHT_LOG2,
                 REG_PLAYER_X, REG_PLAYER_Y};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.set_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Result side: check accepted transfers, then choose next ready value
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind       = m_axis_tuser[0];
            got.valid_res  = m_axis_tuser[1];
            got.column     = m_axis_tdata[10:0];
            got.texture    = m_axis_tdata[13:11];
            got.screen_row = m_axis_tdata[23:14];
            got.tex_col    = m_axis_tdata[31:24];
            got.tex_row    = m_axis_tdata[39:32];
            got.draw_start = m_axis_tdata[49:40];
            got.draw_end   = m_axis_tdata[59:50];
            got.last       = m_axis_tlast;
            sb.check_result(got);
        end
        if (rx_run == 0)
        begin
            rx_on = !rx_on;
            if (rx_on)
                rx_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                    : $urandom_range(1, 30);
            else
                rx_run = pick_gap() + 1;
        end
        else
            rx_run--;
        m_axis_tready <= hold_out ? 1'b0 : (no_idle ? 1'b1 : rx_on);
    end

    // Long receiver hold-off so the input queue fills and backs up
    initial
    begin
        wait (items_sent >= HOLD_AFTER);
        @(posedge clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** wall_column_texture_mapper_unit: FAILED **");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int             budget[6];
        int             target;
        int             n;
        logic [Q_W-1:0] pdist;

        budget = '{235, 235, 120, 270, 270, 270};
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // row with no column, then a far wall that covers no rows
        send_rows(1);
        send_item(MODE_SETUP, 11'd5, 3'd1, 24'hFFFFFF, 1'b0, 24'h010000, 24'hFF0000);
        drain();

        // zero height and width count as one; log2 above the limit saturates,
        // so a one-row slice gives a saturated texture step
        program_regs(24'd0, 24'd0, 24'd15, 24'hFFFFFF, 24'hFFFFFF);
        send_item(MODE_SETUP, 11'd0, 3'd0, 24'hFFFFFF, 1'b1, 24'h800000, 24'hFFFFFF);
        send_rows(1);
        drain();

        // oversized height and width clamp; mirrored column at the extremes
        program_regs(24'd2047, 24'd511, 24'd2, 24'h123456, 24'hFEDCBA);
        send_item(MODE_SETUP, 11'd2047, 3'd7, 24'hFFFFFF, 1'b0, 24'h000001, 24'h7FFFFF);
        send_rows(5);

        // zero distance: full-height slice clamped at both ends
        send_item(MODE_SETUP, 11'd0, 3'd0, 24'h000000, 1'b0, 24'hFFFFFF, 24'h800000);
        send_rows(2);
        drain();

        // texture height changes while that column is still in progress
        program_regs(24'd2047, 24'd511, 24'd15, 24'h123456, 24'hFEDCBA);
        send_rows(2);

        // new set-up replaces the unfinished column
        send_item(MODE_SETUP, 11'd1024, 3'd4, 24'h800000, 1'b1, 24'h7FFFFF, 24'h000000);
        send_rows(8);

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: program_regs(24'd480, 24'd64, 24'd6, 24'd0, 24'd0);
                1: program_regs(24'd1024, 24'd256, 24'd8, 24'hFFFFFF, 24'hFFFFFF);
                2: program_regs(24'd1, 24'd1, 24'd0, 24'd0, 24'd0);
                3: program_regs(24'd2047, 24'd511, 24'd15, Q_W'($urandom), Q_W'($urandom));
                default: program_regs(Q_W'($urandom_range(0, 2047)), Q_W'($urandom_range(0, 511)),
                                      Q_W'($urandom_range(0, 15)), Q_W'($urandom),
                                      Q_W'($urandom));
            endcase
            no_idle = (ph == 1);
            target  = items_sent + budget[ph];
            while (items_sent < target)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_rows(1);
                else
                begin
                    // distance mostly near the wall heights that fit the screen
                    case ($urandom_range(0, 31))
                        0:             pdist = '0;
                        1, 2, 3, 4, 5: pdist = Q_W'($urandom);
                        6, 7:          pdist = Q_W'($urandom_range(24'h100000, 24'hFFFFFF));
                        default:       pdist = Q_W'((u64_t'(sb.eff_height()) << FRAC_BITS)
                                                    / $urandom_range(1, 48)
                                                    + $urandom_range(0, 65535));
                    endcase
                    send_item(MODE_SETUP, COL_W'($urandom), TID_W'($urandom), pdist,
                              1'($urandom), rand_ray(), rand_ray());
                    n = sb.rows_left();
                    // cut some columns short so the next set-up replaces them
                    if ($urandom_range(0, 7) == 0)
                        n = $urandom_range(0, n);
                    send_rows(n);
                    if ($urandom_range(0, 7) == 0)
                        send_rows($urandom_range(1, 3));
                end
            end
        end

        drain();
        no_idle = 1'b0;
        repeat (100) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("expected results left over");
        if (sb.errors == 0)
            $display("** wall_column_texture_mapper_unit: PASSED **");
        else
            $display("** wall_column_texture_mapper_unit: FAILED **");
        $finish;
    end

endmodule

/* wall_column_texture_mapper_unit.f */
rtl/core/wcm_pkg.sv
rtl/core/wcm_front.sv
rtl/core/wcm_queue.sv
rtl/core/wcm_div.sv
rtl/core/wcm_back.sv
rtl/core/wall_column_texture_mapper_unit.sv
tb/testbench.sv
